// ===== hw/rtl/text_console_cursor_scroll_assert.svh =====
// Assertion macros for the console back end, sampled on i_clk and gated by i_rst_n.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define TCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCC_ASSERT(lbl, prop, msg)
`define TCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tcc_pkg.sv =====
// Shared types, codes and constants of the text console.
`timescale 1ns / 1ps
package tcc_pkg;

    localparam int DEF_LINES   = 25;
    localparam int DEF_COLUMNS = 80;
    localparam int CMDQ_DEPTH  = 2;

    localparam logic [7:0]  BLANK_CHAR    = 8'h20;
    localparam logic [7:0]  DEFAULT_STYLE = 8'h0F;
    localparam logic [7:0]  NEWLINE_CHAR  = 8'd10;
    localparam logic [7:0]  NULL_CHAR     = 8'd0;
    localparam logic [15:0] BLANK_CELL    = {BLANK_CHAR, DEFAULT_STYLE};

    // Input modes
    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_SETPOS = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Register index (word address)
    localparam logic REG_FONT_STYLE = 1'b0;

    typedef logic [2:0] t_kind;

    localparam t_kind K_PUT     = 3'd0;
    localparam t_kind K_NEWLINE = 3'd1;
    localparam t_kind K_IGNORE  = 3'd2;
    localparam t_kind K_CLEAR   = 3'd3;
    localparam t_kind K_SETPOS  = 3'd4;
    localparam t_kind K_READ    = 3'd5;
    localparam t_kind K_ERROR   = 3'd6;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [4:0] line;
        logic [6:0] column;
    } t_cmd;

    typedef struct packed {
        logic [4:0] line;
        logic [6:0] column;
        logic [7:0] cell_char;
        logic [7:0] cell_style;
        logic       scrolled;
        logic       range_error;
    } t_result;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic       init_busy;
        logic [7:0] font_style;
    } t_back_status;

endpackage

// ===== hw/rtl/tcc_front.sv =====
// Front end: accepts input items, classifies them and checks their targets.
`timescale 1ns / 1ps
module tcc_front import tcc_pkg::*; #(
    parameter int LINES   = DEF_LINES,
    parameter int COLUMNS = DEF_COLUMNS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [4:0] i_line,
    input  logic [6:0] i_column,
    input  logic       i_hold,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic in_ready;
    logic accept;
    logic bad_target;

    assign o_q_push = r_valid & ~i_q_full;
    assign in_ready = ~i_hold & (~r_valid | ~i_q_full);
    assign o_full   = ~in_ready;
    assign accept   = i_push & in_ready;
    assign o_cmd    = r_cmd;

    assign bad_target = ({1'b0, i_line} >= 6'(LINES)) || ({1'b0, i_column} >= 8'(COLUMNS));

    always_comb begin
        n_cmd.ch     = i_char_code;
        n_cmd.line   = i_line;
        n_cmd.column = i_column;
        case (i_mode)
            MODE_PUT: begin
                if (i_char_code == NEWLINE_CHAR) begin
                    n_cmd.kind = K_NEWLINE;
                end else if (i_char_code == NULL_CHAR) begin
                    n_cmd.kind = K_IGNORE;
                end else begin
                    n_cmd.kind = K_PUT;
                end
            end
            MODE_CLEAR:  n_cmd.kind = K_CLEAR;
            MODE_SETPOS: n_cmd.kind = bad_target ? K_ERROR : K_SETPOS;
            MODE_READ:   n_cmd.kind = bad_target ? K_ERROR : K_READ;
            default:     n_cmd.kind = K_IGNORE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== hw/rtl/tcc_cmd_queue.sv =====
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps
module tcc_cmd_queue import tcc_pkg::*; #(
    parameter int DEPTH = CMDQ_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/tcc_back.sv =====
// Back end: cursor, screen store with row rotation, fill sequencer and result register.
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_assert.svh"
module tcc_back import tcc_pkg::*; #(
    parameter int LINES   = DEF_LINES,
    parameter int COLUMNS = DEF_COLUMNS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cmd_valid,
    input  t_cmd         i_cmd,
    output logic         o_cmd_take,
    input  t_cfg_wr      i_cfg,
    input  logic         i_pop,
    output logic         o_res_valid,
    output t_result      o_res,
    output t_back_status o_status
);

    localparam int CELLS  = LINES * COLUMNS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FILL = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [4:0]        r_line, n_line;
    logic [6:0]        r_col, n_col;
    logic [4:0]        r_base, n_base;
    logic [7:0]        r_style, n_style;
    logic [ADDR_W-1:0] r_fill_addr, n_fill_addr;
    logic [ADDR_W-1:0] r_fill_last, n_fill_last;
    logic              r_fill_first, n_fill_first;
    logic [15:0]       r_first_data, n_first_data;
    logic [15:0]       r_fill_data, n_fill_data;
    logic              r_report, n_report;
    logic              r_scroll, n_scroll;
    logic              r_res_valid;
    t_result           r_res, n_res;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rd_data;

    logic              res_free;
    logic              take;
    logic              res_we;
    logic              res_err;
    logic [15:0]       res_cell;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic [5:0]        line_inc;
    logic              wrap;
    logic              last_line;
    logic [5:0]        row_l;
    logic [6:0]        col_l;
    logic [4:0]        prow;
    logic [ADDR_W-1:0] calc_addr;
    logic [ADDR_W-1:0] row_start;
    logic              do_scroll;
    logic [15:0]       scroll_first;

    // Logical line to physical row of the store; the screen scrolls by moving r_base.
    function automatic logic [4:0] phys_row(input logic [5:0] l, input logic [4:0] base);
        logic [6:0] s;
        s = {1'b0, l} + {2'b00, base};
        if (s >= 7'(LINES)) begin
            s = s - 7'(LINES);
        end
        return s[4:0];
    endfunction

    assign res_free  = ~r_res_valid | i_pop;
    assign line_inc  = {1'b0, r_line} + 6'd1;
    assign last_line = (line_inc >= 6'(LINES));
    assign wrap      = (r_col >= 7'(COLUMNS));

    always_comb begin
        if (i_cmd.kind == K_READ) begin
            row_l = {1'b0, i_cmd.line};
            col_l = i_cmd.column;
        end else if (wrap) begin
            row_l = line_inc;
            col_l = '0;
        end else begin
            row_l = {1'b0, r_line};
            col_l = r_col;
        end
    end

    assign prow      = phys_row(row_l, r_base);
    assign calc_addr = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col_l);
    // The new bottom row after a scroll is the row that was on top, at the old base.
    assign row_start = ADDR_W'(r_base) * ADDR_W'(COLUMNS);

    always_comb begin
        n_state      = r_state;
        n_line       = r_line;
        n_col        = r_col;
        n_base       = r_base;
        n_style      = r_style;
        n_fill_addr  = r_fill_addr;
        n_fill_last  = r_fill_last;
        n_fill_first = r_fill_first;
        n_first_data = r_first_data;
        n_fill_data  = r_fill_data;
        n_report     = r_report;
        n_scroll     = r_scroll;
        take         = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = r_fill_addr;
        mem_wd       = r_fill_first ? r_first_data : r_fill_data;
        res_we       = 1'b0;
        res_err      = 1'b0;
        res_cell     = '0;
        do_scroll    = 1'b0;
        scroll_first = {BLANK_CHAR, r_style};

        if (i_cfg.en) begin
            n_style = i_cfg.data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && res_free) begin
                    take     = 1'b1;
                    n_scroll = 1'b0;
                    case (i_cmd.kind)
                        K_PUT: begin
                            if (wrap && last_line) begin
                                // The character lands in the first cell of the new row.
                                do_scroll    = 1'b1;
                                scroll_first = {i_cmd.ch, r_style};
                                n_col        = 7'd1;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = calc_addr;
                                mem_wd = {i_cmd.ch, r_style};
                                res_we = 1'b1;
                                if (wrap) begin
                                    n_line = line_inc[4:0];
                                    n_col  = 7'd1;
                                end else begin
                                    n_col = r_col + 7'd1;
                                end
                            end
                        end
                        K_NEWLINE: begin
                            n_col = '0;
                            if (last_line) begin
                                do_scroll = 1'b1;
                            end else begin
                                n_line = line_inc[4:0];
                                res_we = 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            n_line       = '0;
                            n_col        = '0;
                            n_base       = '0;
                            n_style      = DEFAULT_STYLE;
                            n_state      = S_FILL;
                            n_fill_addr  = '0;
                            n_fill_last  = ADDR_W'(CELLS - 1);
                            n_fill_first = 1'b0;
                            n_first_data = BLANK_CELL;
                            n_fill_data  = BLANK_CELL;
                            n_report     = 1'b1;
                        end
                        K_SETPOS: begin
                            n_line = i_cmd.line;
                            n_col  = i_cmd.column;
                            res_we = 1'b1;
                        end
                        K_READ: begin
                            n_state = S_READ;
                        end
                        K_ERROR: begin
                            res_we  = 1'b1;
                            res_err = 1'b1;
                        end
                        default: begin
                            res_we = 1'b1;
                        end
                    endcase
                end
            end
            S_FILL: begin
                mem_we       = 1'b1;
                n_fill_first = 1'b0;
                if (r_fill_addr == r_fill_last) begin
                    n_state = S_IDLE;
                    res_we  = r_report;
                end else begin
                    n_fill_addr = r_fill_addr + 1'b1;
                end
            end
            S_READ: begin
                res_we   = 1'b1;
                res_cell = r_rd_data;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_scroll) begin
            n_state      = S_FILL;
            n_base       = phys_row(6'd1, r_base);
            n_line       = 5'(LINES - 1);
            n_fill_addr  = row_start;
            n_fill_last  = row_start + ADDR_W'(COLUMNS - 1);
            n_fill_first = 1'b1;
            n_first_data = scroll_first;
            n_fill_data  = {BLANK_CHAR, r_style};
            n_report     = 1'b1;
            n_scroll     = 1'b1;
        end

        n_res.line        = n_line;
        n_res.column      = n_col;
        n_res.cell_char   = res_cell[15:8];
        n_res.cell_style  = res_cell[7:0];
        n_res.scrolled    = n_scroll;
        n_res.range_error = res_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // After reset the sequencer sweeps the whole store with blanks.
            r_state      <= S_FILL;
            r_line       <= '0;
            r_col        <= '0;
            r_base       <= '0;
            r_style      <= DEFAULT_STYLE;
            r_fill_addr  <= '0;
            r_fill_last  <= ADDR_W'(CELLS - 1);
            r_fill_first <= 1'b0;
            r_first_data <= BLANK_CELL;
            r_fill_data  <= BLANK_CELL;
            r_report     <= 1'b0;
            r_scroll     <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_line       <= n_line;
            r_col        <= n_col;
            r_base       <= n_base;
            r_style      <= n_style;
            r_fill_addr  <= n_fill_addr;
            r_fill_last  <= n_fill_last;
            r_fill_first <= n_fill_first;
            r_first_data <= n_first_data;
            r_fill_data  <= n_fill_data;
            r_report     <= n_report;
            r_scroll     <= n_scroll;
            r_res_valid  <= res_we | (r_res_valid & ~i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[calc_addr];
    end

    assign o_cmd_take         = take;
    assign o_res_valid        = r_res_valid;
    assign o_res              = r_res;
    assign o_status.init_busy = (r_state == S_FILL) && !r_report;
    assign o_status.font_style = r_style;

    `TCC_ASSERT(a_res_no_overwrite, res_we |-> (!r_res_valid || i_pop), "result overwritten")
    `TCC_ASSERT(a_cursor_range, (r_line < 5'(LINES)) && (r_col <= 7'(COLUMNS)), "cursor out of range")
    `TCC_ASSERT(a_fill_bound, (r_state == S_FILL) |-> (r_fill_addr <= r_fill_last), "fill overrun")
    `TCC_ASSERT_NEXT(a_read_result, r_state == S_READ, r_res_valid, "read gave no result")

endmodule

// ===== hw/rtl/text_console_cursor_scroll.sv =====
// Top level of the text console: register port, front end, command queue and back end.
// An item passes the front-end register, the command queue and the back end to the result register;
// a cell read adds a store read, and a scroll or a clear adds a fill of the new row or the whole store.
// Throughput: one item per cycle for a put, newline or set cursor while results are popped; a cell read,
// a scroll or a clear holds the back end until its read or fill is done (one write port).
// Reset (synchronous, active low) homes the cursor, sets the style to 0x0F and then sweeps
// the whole store with blanks before any item is accepted.
`timescale 1ns / 1ps
module text_console_cursor_scroll import tcc_pkg::*; #(
    parameter int LINES   = DEF_LINES,
    parameter int COLUMNS = DEF_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [4:0]  i_line,
    input  logic [6:0]  i_column,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_cursor_line_out,
    output logic [6:0]  o_cursor_column_out,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_style,
    output logic        o_scrolled,
    output logic        o_range_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic         q_push;
    logic         q_full;
    logic         q_valid;
    logic         q_take;
    t_cmd         front_cmd;
    t_cmd         q_cmd;
    t_cfg_wr      cfg_wr;
    t_back_status status;
    t_result      res;
    logic         res_valid;

    assign pready       = 1'b1;
    assign cfg_wr.en    = psel & penable & pwrite & pready & (paddr[2] == REG_FONT_STYLE);
    assign cfg_wr.data  = pwdata[7:0];
    assign prdata       = (paddr[2] == REG_FONT_STYLE) ? {24'd0, status.font_style} : 32'd0;

    tcc_front #(
        .LINES   (LINES),
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_line      (i_line),
        .i_column    (i_column),
        .i_hold      (status.init_busy),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_cmd       (front_cmd)
    );

    tcc_cmd_queue #(
        .DEPTH (CMDQ_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_take),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tcc_back #(
        .LINES   (LINES),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_take  (q_take),
        .i_cfg       (cfg_wr),
        .i_pop       (pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_status    (status)
    );

    assign empty               = ~res_valid;
    assign o_cursor_line_out   = res.line;
    assign o_cursor_column_out = res.column;
    assign o_cell_char         = res.cell_char;
    assign o_cell_style        = res.cell_style;
    assign o_scrolled          = res.scrolled;
    assign o_range_error       = res.range_error;

endmodule
